// ----- rtl/atu_pkg.sv -----
// Shared request codes and port constants for the affine transform unit.
package atu_pkg;

  // Width of every coordinate port and of each half of one configuration data word
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_REGS  = 8;

  typedef enum logic [1:0] {
    REQ_DIR   = 2'd0,
    REQ_POINT = 2'd1,
    REQ_PLANE = 2'd2
  } req_type_e;

endpackage

// ----- rtl/atu_lane.sv -----
// One result component: four signed products plus translation, truncate and saturate.
module atu_lane #(
  parameter int W = 32,
  parameter int F = 16
) (
  input  logic                clk_i,
  input  logic [3:0][W-1:0]   a_i,
  input  logic [3:0][W-1:0]   b_i,
  input  logic [W-1:0]        t_i,
  output logic [W-1:0]        res_o,
  output logic                sat_o
);

  localparam int PROD_W = (2 * W > W + F) ? 2 * W : W + F;
  localparam int PAIR_W = PROD_W + 2;
  localparam int SUM_W  = PROD_W + 3;

  localparam logic signed [SUM_W-1:0] WMAX = $signed({{(SUM_W - W + 1){1'b0}}, {(W - 1){1'b1}}});
  localparam logic signed [SUM_W-1:0] WMIN = ~WMAX;

  logic signed [2*W-1:0]    mul [4];
  logic signed [PROD_W-1:0] prod_d [4];
  logic signed [PROD_W-1:0] prod_q [4];
  logic signed [PROD_W-1:0] tr_d, tr_q;
  logic signed [PAIR_W-1:0] sa_d, sa_q, sb_d, sb_q;
  logic signed [SUM_W-1:0]  sum_d, sum_q;
  logic signed [SUM_W-1:0]  quo;
  logic [W-1:0]             res_d;
  logic                     sat_d;

  // stage 1: multiply
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      mul[k]    = $signed(a_i[k]) * $signed(b_i[k]);
      prod_d[k] = PROD_W'(mul[k]);
    end
    tr_d = PROD_W'($signed(t_i)) <<< F;
  end

  // stage 2: pair sums, translation joins the second pair
  always_comb begin
    sa_d = PAIR_W'(prod_q[0]) + PAIR_W'(prod_q[1]);
    sb_d = PAIR_W'(prod_q[2]) + PAIR_W'(prod_q[3]) + PAIR_W'(tr_q);
  end

  // stage 3: full sum
  assign sum_d = SUM_W'(sa_q) + SUM_W'(sb_q);

  // stage 4: shift toward zero, then clip
  always_comb begin
    quo = sum_q >>> F;
    if (sum_q[SUM_W-1] && (sum_q[F-1:0] != '0)) begin
      quo = quo + SUM_W'(1);
    end
    sat_d = 1'b0;
    res_d = quo[W-1:0];
    if (quo > WMAX) begin
      res_d = WMAX[W-1:0];
      sat_d = 1'b1;
    end else if (quo < WMIN) begin
      res_d = WMIN[W-1:0];
      sat_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      prod_q[k] <= prod_d[k];
    end
    tr_q  <= tr_d;
    sa_q  <= sa_d;
    sb_q  <= sb_d;
    sum_q <= sum_d;
    res_o <= res_d;
    sat_o <= sat_d;
  end

endmodule

// ----- rtl/affine_transform_unit.sv -----
// Top level of the affine transform unit: matrix registers, operand routing, four lanes.
//
// Usage: a request (req_type_i, in_x_i..in_w_i) is taken at a rising edge where
// start is high and busy is low. busy never rises, so one request can enter in
// every cycle. Request kinds: direction (3x3 part), point (3x3 part plus
// translation column) and plane (row vector times the full 4x4).
// Each result appears on out_x_o..out_w_o and saturated_o for exactly one cycle
// with done_o high. Five register stages (input, multiply, two adder stages,
// truncate/saturate) load in turn from the accepting edge on, and done_o rises
// together with the output of the last stage.
// Throughput is one request per cycle; the result side has no backpressure.
// Matrix entries are written over the cfg port (cfg_valid_i, cfg_index_i,
// cfg_data_i); cfg_ready_o is always high. Index i loads row i/2, columns
// 2*(i%2) and +1 from the low and high 32-bit halves. Indexes 8 and up are
// dropped. Write the matrix only while no request is in flight.
// Reset empties the pipeline and loads the identity matrix.
module affine_transform_unit
  import atu_pkg::*;
#(
  parameter int FRAC_BITS  = 16,
  parameter int WORD_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           req_type_i,
  input  logic [DATA_W-1:0]    in_x_i,
  input  logic [DATA_W-1:0]    in_y_i,
  input  logic [DATA_W-1:0]    in_z_i,
  input  logic [DATA_W-1:0]    in_w_i,
  output logic                 done_o,
  output logic [DATA_W-1:0]    out_x_o,
  output logic [DATA_W-1:0]    out_y_o,
  output logic [DATA_W-1:0]    out_z_o,
  output logic [DATA_W-1:0]    out_w_o,
  output logic                 saturated_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int W = WORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam logic [CFG_W-1:0] ONE64 = CFG_W'(1) << F;
  localparam logic [W-1:0]     ONE   = ONE64[W-1:0];

  logic [3:0][3:0][W-1:0] m_q;
  logic [3:0][W-1:0]      v0_q;
  req_type_e              type0_q;
  logic [4:0]             vld_q;

  logic [3:0][3:0][W-1:0] a_op;
  logic [3:0][3:0][W-1:0] b_op;
  logic [3:0][W-1:0]      t_op;
  logic [3:0][W-1:0]      res;
  logic [3:0]             sat;

  logic accept;
  logic [1:0] wr_row;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;
  assign wr_row      = cfg_index_i[2:1];

  // matrix registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          m_q[i][j] <= (i == j) ? ONE : '0;
        end
      end
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(NUM_REGS))) begin
      if (cfg_index_i[0]) begin
        m_q[wr_row][2] <= cfg_data_i[W-1:0];
        m_q[wr_row][3] <= cfg_data_i[32+W-1:32];
      end else begin
        m_q[wr_row][0] <= cfg_data_i[W-1:0];
        m_q[wr_row][1] <= cfg_data_i[32+W-1:32];
      end
    end
  end

  // valid bits for the five stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], accept};
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      type0_q <= req_type_e'(req_type_i);
      v0_q[0] <= in_x_i[W-1:0];
      v0_q[1] <= in_y_i[W-1:0];
      v0_q[2] <= in_z_i[W-1:0];
      v0_q[3] <= in_w_i[W-1:0];
    end
  end

  // operand routing; unused slots stay zero so they add nothing
  always_comb begin
    a_op = '0;
    b_op = '0;
    t_op = '0;
    case (type0_q)
      REQ_DIR, REQ_POINT: begin
        for (int i = 0; i < 3; i++) begin
          for (int k = 0; k < 3; k++) begin
            a_op[i][k] = m_q[i][k];
            b_op[i][k] = v0_q[k];
          end
          if (type0_q == REQ_POINT) begin
            t_op[i] = m_q[i][3];
          end
        end
      end
      REQ_PLANE: begin
        for (int i = 0; i < 4; i++) begin
          for (int k = 0; k < 4; k++) begin
            a_op[i][k] = v0_q[k];
            b_op[i][k] = m_q[k][i];
          end
        end
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    atu_lane #(
      .W (W),
      .F (F)
    ) u_lane (
      .clk_i (clk_i),
      .a_i   (a_op[g]),
      .b_i   (b_op[g]),
      .t_i   (t_op[g]),
      .res_o (res[g]),
      .sat_o (sat[g])
    );
  end

  assign done_o      = vld_q[4];
  assign out_x_o     = DATA_W'($signed(res[0]));
  assign out_y_o     = DATA_W'($signed(res[1]));
  assign out_z_o     = DATA_W'($signed(res[2]));
  assign out_w_o     = DATA_W'($signed(res[3]));
  assign saturated_o = |sat;

  // every result must trace back to an accepted request
  a_done_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 5))
    else $error("result without a matching request");

  // direction and point results carry a zero fourth component
  a_w_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(start && !busy, 5) && $past(req_type_i != REQ_PLANE, 5))
      |-> (out_w_o == '0))
    else $error("out_w nonzero for a non-plane request");

  // out_x_o must be a sign-extended word value
  a_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ((out_x_o[DATA_W-1:W-1] == '0) || (out_x_o[DATA_W-1:W-1] == '1)))
    else $error("out_x not sign-extended");

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the affine transform unit: matrix setups, requests, result checks.
module testbench;
  import atu_pkg::*;

  localparam int FRAC = 16;
  localparam int STALL_LIMIT = 2000;
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  localparam logic [DATA_W-1:0] MAXW = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] MINW = 32'h8000_0000;
  localparam logic [DATA_W-1:0] ONE = 32'h0001_0000;
  localparam logic [DATA_W-1:0] NEG_ONE = 32'hFFFF_0000;
  localparam logic [DATA_W-1:0] HALF = 32'h0000_8000;
  localparam logic [DATA_W-1:0] NEG_HALF = 32'hFFFF_8000;
  localparam logic signed [79:0] WORD_MAX = 80'sh7FFF_FFFF;
  localparam logic signed [79:0] WORD_MIN = -80'sh8000_0000;

  typedef struct packed {
    logic [1:0]        kind;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] w;
  } xform_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [DATA_W-1:0] w;
    logic              sat;
  } xform_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [1:0]           req_type_i = '0;
  logic [DATA_W-1:0]    in_x_i = '0;
  logic [DATA_W-1:0]    in_y_i = '0;
  logic [DATA_W-1:0]    in_z_i = '0;
  logic [DATA_W-1:0]    in_w_i = '0;
  logic                 done_o;
  logic [DATA_W-1:0]    out_x_o;
  logic [DATA_W-1:0]    out_y_o;
  logic [DATA_W-1:0]    out_z_o;
  logic [DATA_W-1:0]    out_w_o;
  logic                 saturated_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;

  // shadow of the matrix registers, identity after reset
  logic [CFG_W-1:0] matrix_q [NUM_REGS] = '{
    64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_0001_0000, 64'h0, 64'h0001_0000_0000_0000
  };

  xform_req_t pending_reqs[$];
  xform_res_t expected_results[$];
  logic       steady_feed = 1'b0;
  int         mismatches = 0;
  int         idle_cycles = 0;

  affine_transform_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .in_x_i      (in_x_i),
    .in_y_i      (in_y_i),
    .in_z_i      (in_z_i),
    .in_w_i      (in_w_i),
    .done_o      (done_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o),
    .out_w_o     (out_w_o),
    .saturated_o (saturated_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic logic signed [DATA_W-1:0] matrix_entry(int row, int col);
    logic [CFG_W-1:0] word;
    word = matrix_q[row * 2 + col / 2];
    return (col % 2) ? word[63:32] : word[31:0];
  endfunction

  // Exact sum of products, truncated toward zero, clipped to 32 bits.
  function automatic xform_res_t predict_transform(xform_req_t rq);
    logic signed [DATA_W-1:0] vec [4];
    logic [DATA_W-1:0]        comp [4];
    logic signed [79:0]       acc, lhs, rhs, quo;
    logic                     sat;
    int                       lanes;
    vec[0] = rq.x;
    vec[1] = rq.y;
    vec[2] = rq.z;
    vec[3] = rq.w;
    sat = 1'b0;
    lanes = 0;
    if (rq.kind == REQ_DIR || rq.kind == REQ_POINT) lanes = 3;
    else if (rq.kind == REQ_PLANE) lanes = 4;
    for (int i = 0; i < 4; i++) comp[i] = '0;
    for (int i = 0; i < lanes; i++) begin
      acc = '0;
      for (int k = 0; k < lanes; k++) begin
        lhs = vec[k];
        rhs = (rq.kind == REQ_PLANE) ? matrix_entry(k, i) : matrix_entry(i, k);
        acc = acc + lhs * rhs;
      end
      if (rq.kind == REQ_POINT) begin
        rhs = matrix_entry(i, 3);
        acc = acc + (rhs <<< FRAC);
      end
      quo = acc >>> FRAC;
      if (acc < 0 && acc[FRAC-1:0] != '0) quo = quo + 1;
      if (quo > WORD_MAX) begin
        comp[i] = MAXW;
        sat = 1'b1;
      end else if (quo < WORD_MIN) begin
        comp[i] = MINW;
        sat = 1'b1;
      end else begin
        comp[i] = quo[DATA_W-1:0];
      end
    end
    return '{x: comp[0], y: comp[1], z: comp[2], w: comp[3], sat: sat};
  endfunction

  // modest magnitudes for small_pct percent of calls, full-range words up to 92 percent, corner values otherwise
  function automatic logic [DATA_W-1:0] pick_word(int small_pct);
    logic [DATA_W-1:0] raw;
    int                roll;
    raw = $urandom();
    roll = $urandom_range(99);
    if (roll < small_pct) return {{12{raw[19]}}, raw[19:0]};
    if (roll < 92) return raw;
    case (raw[2:0])
      3'd0: return MAXW;
      3'd1: return MINW;
      3'd2: return '0;
      3'd3: return ONE;
      3'd4: return NEG_ONE;
      3'd5: return '1;
      default: return 32'd1;
    endcase
  endfunction

  function automatic void queue_req(logic [1:0] kind, logic [DATA_W-1:0] x, y, z, w);
    pending_reqs.push_back('{kind: kind, x: x, y: y, z: z, w: w});
  endfunction

  // Leaves valid high; the caller drops it after the last write.
  task automatic write_matrix_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if ($urandom_range(99) < 18) begin
      cfg_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx < CFG_IDX_W'(NUM_REGS)) matrix_q[idx[2:0]] = data;
  endtask

  // sample at the falling edge so the driver and checker have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || start || expected_results.size() != 0);
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : feed_requests
    xform_req_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_results.push_back(predict_transform('{kind: req_type_i, x: in_x_i,
                                                       y: in_y_i, z: in_z_i, w: in_w_i}));
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && (steady_feed || $urandom_range(99) >= 18)) begin
          nxt = pending_reqs.pop_front();
          start      <= 1'b1;
          req_type_i <= nxt.kind;
          in_x_i     <= nxt.x;
          in_y_i     <= nxt.y;
          in_z_i     <= nxt.z;
          in_w_i     <= nxt.w;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    xform_res_t got, want;
    if (rst_ni && done_o) begin
      got = '{x: out_x_o, y: out_y_o, z: out_z_o, w: out_w_o, sat: saturated_o};
      if (expected_results.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result x=%h y=%h z=%h w=%h sat=%b",
                   got.x, got.y, got.z, got.w, got.sat);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.w !== want.w || got.sat !== want.sat) begin
          if (mismatches < 10)
            $display("mismatch: expected x=%h y=%h z=%h w=%h sat=%b, got x=%h y=%h z=%h w=%h sat=%b",
                     want.x, want.y, want.z, want.w, want.sat,
                     got.x, got.y, got.z, got.w, got.sat);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : sequencer
    int         small_pct;
    int         roll;
    logic [1:0] kind;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity matrix straight out of reset
    @(negedge clk_i);
    queue_req(REQ_DIR, '0, '0, '0, '0);
    queue_req(REQ_DIR, MAXW, MINW, '1, MAXW);
    queue_req(REQ_POINT, ONE, NEG_ONE, MAXW, MINW);
    queue_req(REQ_PLANE, MAXW, MINW, 32'd1, '1);
    queue_req(REQ_PLANE, MINW, MINW, MINW, MINW);
    queue_req(REQ_RESERVED, MAXW, MINW, ONE, NEG_ONE);

    // full-scale entries of both signs: overflow on nearly every lane
    wait_drained();
    for (int r = 0; r < NUM_REGS; r++)
      write_matrix_reg(CFG_IDX_W'(r), r[0] ? {MINW, MAXW} : {MAXW, MINW});
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    queue_req(REQ_DIR, MAXW, MAXW, MAXW, '0);
    queue_req(REQ_DIR, MINW, MINW, MINW, MINW);
    queue_req(REQ_POINT, '0, '0, '0, MAXW);
    queue_req(REQ_PLANE, MAXW, MINW, MAXW, MINW);
    queue_req(REQ_RESERVED, MAXW, MAXW, MAXW, MAXW);

    // +0.5 / -0.5 entries: negative fractions must truncate toward zero
    wait_drained();
    for (int r = 0; r < NUM_REGS; r++)
      write_matrix_reg(CFG_IDX_W'(r), {NEG_HALF, HALF});
    write_matrix_reg(CFG_IDX_W'(NUM_REGS), '1);
    write_matrix_reg(4'hF, '0);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    queue_req(REQ_DIR, '1, '0, '0, '0);
    queue_req(REQ_DIR, 32'd1, '0, '0, '0);
    queue_req(REQ_DIR, 32'hFFFF_FFFD, '0, '0, '0);
    queue_req(REQ_POINT, '1, 32'd1, '1, '0);
    queue_req(REQ_PLANE, '1, '1, '1, '1);
    queue_req(REQ_PLANE, MAXW, MAXW, MAXW, MAXW);

    for (int ph = 0; ph < 8; ph++) begin
      wait_drained();
      small_pct = (ph % 2) ? 30 : 85;
      for (int r = 0; r < NUM_REGS; r++)
        if ($urandom_range(99) < 70)
          write_matrix_reg(CFG_IDX_W'(r), {pick_word(small_pct), pick_word(small_pct)});
      if ($urandom_range(3) == 0)
        write_matrix_reg(CFG_IDX_W'($urandom_range(15, NUM_REGS)), {$urandom(), $urandom()});
      cfg_valid_i <= 1'b0;
      @(negedge clk_i);
      steady_feed = (ph == 3);
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(99);
        if (roll < 31) kind = REQ_DIR;
        else if (roll < 62) kind = REQ_POINT;
        else if (roll < 93) kind = REQ_PLANE;
        else kind = REQ_RESERVED;
        queue_req(kind, pick_word(small_pct), pick_word(small_pct),
                  pick_word(small_pct), pick_word(small_pct));
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_results.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/atu_pkg.sv
rtl/atu_lane.sv
rtl/affine_transform_unit.sv
test/testbench.sv
